FILE: design/mfbb_pkg.sv
// shared types, codes and default sizes for the monochrome frame buffer blitter
package mfbb_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 128;
  localparam int unsigned DEF_SCREEN_HEIGHT = 128;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = CFG_IDX_W'(3);

  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;

  typedef enum logic [1:0] {
    OP_BLIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_ERROR      = 2'd2,
    ST_READ_VALID = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [6:0] read_row;
    logic [3:0] read_column_byte;
  } blit_cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] read_value;
  } blit_res_t;

endpackage

FILE: design/mono_framebuffer_bit_blit.sv
// monochrome frame buffer with streaming bit blit, clear and byte read
// an error answers straight from idle; a read passes S_SETUP, S_FETCH0 and S_MOD0, as does
// a blit byte, which adds S_FETCH1 and S_MOD1 when it straddles two stored bytes;
// clear sweeps the store; busy is high until the result shows; results cannot stall
// the single-port store gives one access a cycle, which sets the read-modify-write steps
// reset sweeps all STORE_BYTES bytes of the store white (2048 by default), busy high
module mono_framebuffer_bit_blit #(
  parameter int unsigned SCREEN_WIDTH  = mfbb_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = mfbb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mfbb_pkg::blit_cmd_t            cmd_i,
  output logic                           result_valid_o,
  output mfbb_pkg::blit_res_t            res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mfbb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import mfbb_pkg::*;

  localparam int unsigned ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int unsigned STORE_BYTES = SCREEN_HEIGHT * ROW_BYTES;
  localparam int unsigned AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned MW          = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SETUP,
    S_FETCH0,
    S_MOD0,
    S_FETCH1,
    S_MOD1
  } state_e;

  state_e    state_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    fill_q;
  logic          report_q;
  logic          done_q;
  blit_res_t     res_q;
  blit_cmd_t     cmd_q;
  status_e       status_q;
  logic [15:0]   mask_q;
  logic [15:0]   data_q;
  logic [7:0]    rdata_q;

  logic [6:0] win_x_q;
  logic [6:0] win_y_q;
  logic [7:0] win_w_q;
  logic [7:0] win_h_q;
  logic [7:0] row_cnt_q;
  logic [7:0] pos_q;

  logic [7:0] mem [STORE_BYTES];

  logic          accept;
  logic          win_ok;
  logic          read_ok;
  logic [7:0]    remaining;
  logic [3:0]    nbits;
  logic [8:0]    col;
  logic [8:0]    blit_row;
  logic [8:0]    row_sel;
  logic [5:0]    col_sel;
  logic [MW-1:0] addr_full;
  logic [7:0]    mask8;
  logic [7:0]    new_pos;
  logic [7:0]    next_row;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  assign busy           = (state_q != S_IDLE);
  assign accept         = start && !busy;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = done_q;
  assign res_o          = res_q;

  always_comb begin
    win_ok = (win_w_q != 8'd0) && (win_h_q != 8'd0) &&
             ((10'(win_x_q) + 10'(win_w_q)) <= 10'(SCREEN_WIDTH)) &&
             ((10'(win_y_q) + 10'(win_h_q)) <= 10'(SCREEN_HEIGHT));
    read_ok = (10'(cmd_i.read_row) < 10'(SCREEN_HEIGHT)) &&
              (10'(cmd_i.read_column_byte) < 10'(SCREEN_WIDTH / 8));
    remaining = win_w_q - pos_q;
    nbits     = (remaining < 8'd8) ? remaining[3:0] : 4'd8;
    col       = 9'(win_x_q) + 9'(pos_q);
    blit_row  = 9'(win_y_q) + 9'(row_cnt_q);
    // top nbits set, then slid right by the pixel offset across two bytes
    mask8     = ~(8'hFF >> nbits);
    new_pos   = pos_q + 8'(nbits);
    next_row  = row_cnt_q + 8'd1;
    if (op_e'(cmd_q.operation) == OP_READ) begin
      row_sel = 9'(cmd_q.read_row);
      col_sel = 6'(cmd_q.read_column_byte);
    end else begin
      row_sel = blit_row;
      col_sel = col[8:3];
    end
    addr_full = MW'(row_sel) * MW'(ROW_BYTES) + MW'(col_sel);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = fill_q;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_MOD0: begin
        mem_we    = (op_e'(cmd_q.operation) == OP_BLIT);
        mem_wdata = (rdata_q & ~mask_q[15:8]) | (data_q[15:8] & mask_q[15:8]);
      end
      S_MOD1: begin
        mem_we    = 1'b1;
        mem_wdata = (rdata_q & ~mask_q[7:0]) | (data_q[7:0] & mask_q[7:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      fill_q    <= FILL_WHITE;
      report_q  <= 1'b0;
      done_q    <= 1'b0;
      res_q     <= '0;
      cmd_q     <= '0;
      status_q  <= ST_ACCEPTED;
      mask_q    <= '0;
      data_q    <= '0;
      win_x_q   <= 7'd0;
      win_y_q   <= 7'd0;
      win_w_q   <= 8'd1;
      win_h_q   <= 8'd1;
      row_cnt_q <= 8'd0;
      pos_q     <= 8'd0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_i;
            case (op_e'(cmd_i.operation))
              OP_BLIT: begin
                if (!win_ok || (row_cnt_q >= win_h_q)) begin
                  done_q <= 1'b1;
                  res_q  <= '{status: ST_ERROR, read_value: 8'h00};
                end else begin
                  state_q <= S_SETUP;
                end
              end
              OP_CLEAR: begin
                addr_q   <= '0;
                fill_q   <= (cmd_i.data_byte != 8'h00) ? FILL_BLACK : FILL_WHITE;
                report_q <= 1'b1;
                state_q  <= S_CLEAR;
              end
              OP_READ: begin
                if (read_ok) begin
                  state_q <= S_SETUP;
                end else begin
                  done_q <= 1'b1;
                  res_q  <= '{status: ST_ERROR, read_value: 8'h00};
                end
              end
              default: begin
                done_q <= 1'b1;
                res_q  <= '{status: ST_ERROR, read_value: 8'h00};
              end
            endcase
          end
        end
        S_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == AW'(STORE_BYTES - 1)) begin
            state_q <= S_IDLE;
            if (report_q) begin
              done_q <= 1'b1;
              res_q  <= '{status: ST_ACCEPTED, read_value: 8'h00};
            end
          end
        end
        S_SETUP: begin
          addr_q  <= addr_full[AW-1:0];
          mask_q  <= {mask8, 8'h00} >> col[2:0];
          data_q  <= {cmd_q.data_byte, 8'h00} >> col[2:0];
          state_q <= S_FETCH0;
          if (op_e'(cmd_q.operation) == OP_BLIT) begin
            status_q <= ST_ACCEPTED;
            if (new_pos >= win_w_q) begin
              pos_q     <= 8'd0;
              row_cnt_q <= next_row;
              if (next_row >= win_h_q) begin
                status_q <= ST_COMPLETE;
              end
            end else begin
              pos_q <= new_pos;
            end
          end
        end
        S_FETCH0: begin
          state_q <= S_MOD0;
        end
        S_MOD0: begin
          if (op_e'(cmd_q.operation) == OP_READ) begin
            done_q  <= 1'b1;
            res_q   <= '{status: ST_READ_VALID, read_value: rdata_q};
            state_q <= S_IDLE;
          end else if (mask_q[7:0] != 8'h00) begin
            // the byte straddles into the next stored byte of the row
            addr_q  <= addr_q + AW'(1);
            state_q <= S_FETCH1;
          end else begin
            done_q  <= 1'b1;
            res_q   <= '{status: status_q, read_value: 8'h00};
            state_q <= S_IDLE;
          end
        end
        S_FETCH1: begin
          state_q <= S_MOD1;
        end
        S_MOD1: begin
          done_q  <= 1'b1;
          res_q   <= '{status: status_q, read_value: 8'h00};
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // any write to a window register restarts the blit
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WINDOW_X: begin
            win_x_q   <= cfg_data_i[6:0];
            row_cnt_q <= 8'd0;
            pos_q     <= 8'd0;
          end
          CFG_WINDOW_Y: begin
            win_y_q   <= cfg_data_i[6:0];
            row_cnt_q <= 8'd0;
            pos_q     <= 8'd0;
          end
          CFG_WINDOW_WIDTH: begin
            win_w_q   <= cfg_data_i;
            row_cnt_q <= 8'd0;
            pos_q     <= 8'd0;
          end
          CFG_WINDOW_HEIGHT: begin
            win_h_q   <= cfg_data_i;
            row_cnt_q <= 8'd0;
            pos_q     <= 8'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // an accepted command either answers at once or keeps the sequencer busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || result_valid_o))
    else $error("accepted command neither answered nor started");

  // the store is only written while the sequencer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> busy)
    else $error("store written while idle");

  // the second read-modify-write only happens for a straddling byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH1) |-> (mask_q[7:0] != 8'h00))
    else $error("second store access with an empty mask");

  // read data only ever shows with a valid read status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (res_o.status != ST_READ_VALID)) |-> (res_o.read_value == 8'h00))
    else $error("nonzero read value on a non-read result");
`endif

endmodule
